// ----- rtl/core/apu_frame_sequencer_unit_defines.svh -----
`ifndef APU_FRAME_SEQUENCER_UNIT_DEFINES_SVH
`define APU_FRAME_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define AFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apu frame sequencer check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define AFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apu frame sequencer check failed");

`endif

// ----- rtl/core/afs_pkg.sv -----
`default_nettype none

package afs_pkg;

    // Transaction kinds on the input channel.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Frame count compare points.
    localparam int unsigned COUNT_W = 15;
    localparam logic [COUNT_W-1:0] STEP_Q1  = 15'd3729;
    localparam logic [COUNT_W-1:0] STEP_Q2  = 15'd7457;
    localparam logic [COUNT_W-1:0] STEP_Q3  = 15'd11186;
    localparam logic [COUNT_W-1:0] END_FOUR = 15'd14916;
    localparam logic [COUNT_W-1:0] END_FIVE = 15'd18641;

    // Mode register bit positions.
    localparam int unsigned BIT_FIVE    = 7;
    localparam int unsigned BIT_INHIBIT = 6;

    // Phase counter runs 0 to PHASE_LAST.
    localparam logic [2:0] PHASE_LAST  = 3'd5;
    localparam logic [2:0] PHASE_APU   = 3'd0;
    localparam logic [2:0] PHASE_TIMER = 3'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic timer_pulse;
        logic apu_pulse;
        logic quarter_pulse;
        logic half_pulse;
        logic irq_level;
        logic status_irq;
    } t_out_item;

endpackage

`default_nettype wire

// ----- rtl/core/afs_step.sv -----
`default_nettype none

// Sequencer state and the single-pass logic that turns one transaction into its result.
module afs_step (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire afs_pkg::t_in_item i_item,
    output afs_pkg::t_out_item     o_result
);

    logic [2:0]                   r_phase,       n_phase;
    logic [afs_pkg::COUNT_W-1:0]  r_frame_count, n_frame_count;
    logic                         r_five_step,   n_five_step;
    logic                         r_inhibit,     n_inhibit;
    logic                         r_irq_pending, n_irq_pending;
    logic [afs_pkg::COUNT_W-1:0]  w_count_inc;
    logic [afs_pkg::COUNT_W-1:0]  w_end_count;

    assign w_count_inc = r_frame_count + afs_pkg::COUNT_W'(1);
    assign w_end_count = r_five_step ? afs_pkg::END_FIVE : afs_pkg::END_FOUR;

    // Next state and result for the transaction held in the input register.
    always_comb begin
        n_phase       = r_phase;
        n_frame_count = r_frame_count;
        n_five_step   = r_five_step;
        n_inhibit     = r_inhibit;
        n_irq_pending = r_irq_pending;
        o_result      = '0;

        case (i_item.kind)
            afs_pkg::KIND_TICK: begin
                o_result.timer_pulse = (r_phase == afs_pkg::PHASE_APU) ||
                                       (r_phase == afs_pkg::PHASE_TIMER);
                if (r_phase == afs_pkg::PHASE_APU) begin
                    o_result.apu_pulse = 1'b1;
                    n_frame_count      = w_count_inc;
                    if (w_count_inc == afs_pkg::STEP_Q1 || w_count_inc == afs_pkg::STEP_Q3) begin
                        o_result.quarter_pulse = 1'b1;
                    end else if (w_count_inc == afs_pkg::STEP_Q2) begin
                        o_result.quarter_pulse = 1'b1;
                        o_result.half_pulse    = 1'b1;
                    end else if (w_count_inc == w_end_count) begin
                        o_result.quarter_pulse = 1'b1;
                        o_result.half_pulse    = 1'b1;
                        n_frame_count          = '0;
                        if (!r_five_step && !r_inhibit) begin
                            n_irq_pending = 1'b1;
                        end
                    end
                end
                n_phase = (r_phase == afs_pkg::PHASE_LAST) ? 3'd0 : r_phase + 3'd1;
            end
            afs_pkg::KIND_WRITE: begin
                n_five_step   = i_item.write_data[afs_pkg::BIT_FIVE];
                n_inhibit     = i_item.write_data[afs_pkg::BIT_INHIBIT];
                n_frame_count = '0;
                if (i_item.write_data[afs_pkg::BIT_INHIBIT]) begin
                    n_irq_pending = 1'b0;
                end
                o_result.quarter_pulse = i_item.write_data[afs_pkg::BIT_FIVE];
                o_result.half_pulse    = i_item.write_data[afs_pkg::BIT_FIVE];
            end
            afs_pkg::KIND_READ: begin
                o_result.status_irq = r_irq_pending;
                n_irq_pending       = 1'b0;
            end
            default: begin
            end
        endcase

        o_result.irq_level = n_irq_pending;
    end

    // State advances only when the transaction moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= '0;
            r_frame_count <= '0;
            r_five_step   <= 1'b0;
            r_inhibit     <= 1'b0;
            r_irq_pending <= 1'b0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_frame_count <= n_frame_count;
            r_five_step   <= n_five_step;
            r_inhibit     <= n_inhibit;
            r_irq_pending <= n_irq_pending;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/apu_frame_sequencer_unit.sv -----
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_ready    i_in_data  (afs_pkg::t_in_item)
// out      output     o_out_valid / i_out_ready  o_out_data (afs_pkg::t_out_item)
//
// One transaction is accepted per cycle unless the result stalls; it waits in the input
// register and its result in the result register. The rate is set by the single step of
// the state logic between the two registers. Reset clears all state and both valid flags.
// A stalled result holds in the result register while the input register
// still takes one more transaction.
`default_nettype none

module apu_frame_sequencer_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire afs_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output afs_pkg::t_out_item     o_out_data
);

    logic               r_in_valid;
    afs_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    afs_pkg::t_out_item r_out_item;
    afs_pkg::t_out_item w_result;
    logic               w_advance;

    // The held transaction moves on when the result register is free or draining.
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    afs_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    // Valid flags of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
        if (w_advance) begin
            r_out_item <= w_result;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/afs_checker.sv -----
`default_nettype none
`include "apu_frame_sequencer_unit_defines.svh"

// Port-level checks on the frame sequencer.
module afs_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_ready,
    input  wire afs_pkg::t_out_item o_out_data
);

    // A stalled result transaction keeps its valid and its payload.
    `AFS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // The apu pulse only falls on phase zero, which also drives the timer pulse.
    `AFS_ASSERT_NOW(a_apu_has_timer, i_clk, i_rst_n, o_out_valid && o_out_data.apu_pulse, o_out_data.timer_pulse)

    // Every half-frame pulse comes with a quarter-frame pulse.
    `AFS_ASSERT_NOW(a_half_has_quarter, i_clk, i_rst_n, o_out_valid && o_out_data.half_pulse, o_out_data.quarter_pulse)

    // A status read that reports the interrupt clears it and carries no timer or quarter pulse.
    `AFS_ASSERT_NOW(a_read_clears, i_clk, i_rst_n, o_out_valid && o_out_data.status_irq, !o_out_data.irq_level && !o_out_data.timer_pulse && !o_out_data.quarter_pulse)

    // The timer pulse only comes from a tick, which never returns a status.
    `AFS_ASSERT_NOW(a_tick_no_status, i_clk, i_rst_n, o_out_valid && o_out_data.timer_pulse, !o_out_data.status_irq)

endmodule

bind apu_frame_sequencer_unit afs_checker u_afs_checker (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    // Kind code that the block must ignore; the package names only the three used ones.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT  = 20_000;
    localparam int unsigned MIX_ITEMS    = 480;
    localparam int unsigned QUIET_ITEMS  = 150;
    localparam int unsigned REPORT_CAP   = 100;

    // Predicts the pulses of each transaction and checks them in order.
    class frame_pulse_checker;
        logic [2:0]                  seq_phase;
        logic [afs_pkg::COUNT_W-1:0] frame_cnt;
        logic                        five_mode;
        logic                        irq_mask;
        logic                        irq_flag;
        afs_pkg::t_out_item          pending_results[$];
        int unsigned                 errors;

        function new();
            seq_phase = '0;
            frame_cnt = '0;
            five_mode = 1'b0;
            irq_mask  = 1'b0;
            irq_flag  = 1'b0;
            errors    = 0;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        // Advance the predicted state by one accepted transaction.
        function void accept_item(afs_pkg::t_in_item item);
            afs_pkg::t_out_item          res;
            logic [afs_pkg::COUNT_W-1:0] end_cnt;
            res = '0;
            case (item.kind)
                afs_pkg::KIND_TICK: begin
                    res.timer_pulse = (seq_phase == afs_pkg::PHASE_APU) ||
                                      (seq_phase == afs_pkg::PHASE_TIMER);
                    if (seq_phase == afs_pkg::PHASE_APU) begin
                        end_cnt = five_mode ? afs_pkg::END_FIVE : afs_pkg::END_FOUR;
                        res.apu_pulse = 1'b1;
                        frame_cnt = frame_cnt + 1'b1;
                        if (frame_cnt == afs_pkg::STEP_Q1 || frame_cnt == afs_pkg::STEP_Q3) begin
                            res.quarter_pulse = 1'b1;
                        end else if (frame_cnt == afs_pkg::STEP_Q2) begin
                            res.quarter_pulse = 1'b1;
                            res.half_pulse    = 1'b1;
                        end else if (frame_cnt == end_cnt) begin
                            res.quarter_pulse = 1'b1;
                            res.half_pulse    = 1'b1;
                            if (!five_mode && !irq_mask) begin
                                irq_flag = 1'b1;
                            end
                            frame_cnt = '0;
                        end
                    end
                    seq_phase = (seq_phase == afs_pkg::PHASE_LAST) ? 3'd0 : seq_phase + 3'd1;
                end
                afs_pkg::KIND_WRITE: begin
                    five_mode = item.write_data[afs_pkg::BIT_FIVE];
                    irq_mask  = item.write_data[afs_pkg::BIT_INHIBIT];
                    if (irq_mask) begin
                        irq_flag = 1'b0;
                    end
                    frame_cnt = '0;
                    // A write that selects five-step mode clocks quarter and half at once.
                    if (five_mode) begin
                        res.quarter_pulse = 1'b1;
                        res.half_pulse    = 1'b1;
                    end
                end
                afs_pkg::KIND_READ: begin
                    res.status_irq = irq_flag;
                    irq_flag = 1'b0;
                end
                default: begin
                end
            endcase
            res.irq_level = irq_flag;
            pending_results.push_back(res);
        endfunction

        function void compare_field(string field, logic want, logic got);
            if (want !== got) begin
                errors++;
                if (errors <= REPORT_CAP) begin
                    $display("%0t: %s mismatch, expected %0b actual %0b",
                             $time, field, want, got);
                end
            end
        endfunction

        // Compare one output transaction with the oldest prediction.
        function void check_result(afs_pkg::t_out_item got);
            afs_pkg::t_out_item want;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP) begin
                    $display("%0t: unexpected result, expected none actual %b", $time, got);
                end
                return;
            end
            want = pending_results.pop_front();
            compare_field("timer_pulse",   want.timer_pulse,   got.timer_pulse);
            compare_field("apu_pulse",     want.apu_pulse,     got.apu_pulse);
            compare_field("quarter_pulse", want.quarter_pulse, got.quarter_pulse);
            compare_field("half_pulse",    want.half_pulse,    got.half_pulse);
            compare_field("irq_level",     want.irq_level,     got.irq_level);
            compare_field("status_irq",    want.status_irq,    got.status_irq);
        endfunction
    endclass

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               in_valid   = 1'b0;
    afs_pkg::t_in_item  in_data    = '0;
    logic               out_ready  = 1'b0;
    logic               in_ready;
    logic               out_valid;
    afs_pkg::t_out_item out_data;
    logic               idle_on    = 1'b1;

    frame_pulse_checker board;

    apu_frame_sequencer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Signals settle between edges, so both handshakes are sampled on the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                board.accept_item(in_data);
            end
            if (out_valid && out_ready) begin
                board.check_result(out_data);
            end
        end
    end

    // Receiver side: ready drops in short random bursts while idling is enabled.
    initial begin
        forever begin
            if (idle_on && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Offer one transaction and return at the edge that accepts it.
    task automatic push_item(input logic [1:0] kind, input logic [7:0] data);
        afs_pkg::t_in_item item;
        item.kind       = kind;
        item.write_data = data;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do begin
            @(negedge i_clk);
        end while (!in_ready);
        @(posedge i_clk);
    endtask

    // Hold the sender off until every predicted result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [1:0] random_kind();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return afs_pkg::KIND_TICK;
        end else if (pick < 78) begin
            return afs_pkg::KIND_WRITE;
        end else if (pick < 95) begin
            return afs_pkg::KIND_READ;
        end
        return KIND_SPARE;
    endfunction

    initial begin
        board = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every phase, mode writes, status reads and the ignored kind.
        repeat (7) push_item(afs_pkg::KIND_TICK, 8'h00);
        push_item(afs_pkg::KIND_WRITE, 8'h80);
        push_item(afs_pkg::KIND_TICK, 8'hFF);
        push_item(afs_pkg::KIND_WRITE, 8'h00);
        push_item(afs_pkg::KIND_WRITE, 8'hC0);
        push_item(afs_pkg::KIND_WRITE, 8'h40);
        push_item(afs_pkg::KIND_READ, 8'h00);
        push_item(KIND_SPARE, 8'hFF);
        push_item(afs_pkg::KIND_WRITE, 8'h3F);
        push_item(afs_pkg::KIND_READ, 8'hFF);
        repeat (3) push_item(afs_pkg::KIND_TICK, 8'h55);
        push_item(afs_pkg::KIND_WRITE, 8'hFF);
        push_item(afs_pkg::KIND_TICK, 8'hAA);
        drain_results();

        // Random mix of transactions, ending without any idling.
        for (int unsigned n = 0; n < MIX_ITEMS; n++) begin
            if (n == MIX_ITEMS - QUIET_ITEMS) begin
                idle_on <= 1'b0;
            end
            push_item(random_kind(), 8'($urandom_range(0, 255)));
        end
        drain_results();

        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
